### rtl/core/atr_pkg.sv
// Shared types, constants and helpers for the tensor rotation pipeline.
`default_nettype none
package atr_pkg;
    localparam int COND_W = 48;
    localparam int ANG_W  = 26;
    localparam int OUT_W  = 49;
    localparam int IN_DW  = 224;
    localparam int OUT_DW = 296;
    localparam int N_LANE = 3;
    localparam int N_ENT  = 6;

    localparam int CORDIC_STEPS = 30;
    localparam int CW = 34;     // cordic datapath width
    localparam int MW = 32;     // rotation matrix entry width
    localparam int PW = 66;     // product / sum width

    localparam int DEG_HALF = 180;
    localparam logic signed [ANG_W:0] FULL_TURN = (ANG_W+1)'(2 * DEG_HALF * 65536);
    localparam logic [24:0] QUARTER_1 = 25'(DEG_HALF * 65536 / 2);
    localparam logic [24:0] QUARTER_2 = 25'(DEG_HALF * 65536);
    localparam logic [24:0] QUARTER_3 = 25'(3 * DEG_HALF * 65536 / 2);

    // pi/180 in Q.46, split for two narrow multipliers
    localparam logic [63:0] DEG_TO_RAD = 64'd1228166276394;
    localparam logic [20:0] D2R_HI = DEG_TO_RAD[40:20];
    localparam logic [19:0] D2R_LO = DEG_TO_RAD[19:0];

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [PW-1:0] HALF_Q30 = 66'sd536870912;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
    };

    // row / column of each unique tensor entry
    localparam int ENT_I [N_ENT] = '{0, 0, 0, 1, 1, 2};
    localparam int ENT_J [N_ENT] = '{0, 1, 2, 1, 2, 2};

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } t_cvec;

    // round-half-up of a Q60 value to Q30
    function automatic logic signed [35:0] rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + HALF_Q30;
        return s[PW-1:30];
    endfunction
endpackage
`default_nettype wire

### rtl/core/atr_angle_prep.sv
// Angle reduction to a quadrant and a radian remainder, three stages.
`default_nettype none
module atr_angle_prep (
    input  wire logic                        i_clk,
    input  wire logic [2:0]                  i_en,
    input  wire logic signed [atr_pkg::ANG_W-1:0] i_angle,
    output logic [atr_pkg::CW-1:0]           o_z,
    output atr_pkg::t_quad                   o_quad
);
    import atr_pkg::*;

    logic signed [ANG_W:0] dd, r1;
    logic [24:0]           ru, rem25;
    t_quad                 quad0;

    logic [22:0] r_rem;
    t_quad       r_q0, r_q1, r_q2;
    logic [43:0] r_ph;
    logic [42:0] r_pl;
    logic [63:0] sum;
    logic [CW-1:0] r_z;

    always_comb begin
        dd = (ANG_W+1)'(i_angle);
        if (dd < 0) begin
            r1 = dd + FULL_TURN;
            if (r1 < 0) r1 = r1 + FULL_TURN;
        end else if (dd >= FULL_TURN) begin
            r1 = dd - FULL_TURN;
        end else begin
            r1 = dd;
        end
        ru = r1[24:0];
        priority if (ru >= QUARTER_3) begin
            quad0 = QUAD_3; rem25 = ru - QUARTER_3;
        end else if (ru >= QUARTER_2) begin
            quad0 = QUAD_2; rem25 = ru - QUARTER_2;
        end else if (ru >= QUARTER_1) begin
            quad0 = QUAD_1; rem25 = ru - QUARTER_1;
        end else begin
            quad0 = QUAD_0; rem25 = ru;
        end
    end

    assign sum = {r_ph, 20'b0} + 64'(r_pl);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem <= rem25[22:0];
            r_q0  <= quad0;
        end
        if (i_en[1]) begin
            r_ph <= 44'(r_rem) * 44'(D2R_HI);
            r_pl <= 43'(r_rem) * 43'(D2R_LO);
            r_q1 <= r_q0;
        end
        if (i_en[2]) begin
            r_z  <= {2'b00, sum[63:32]};
            r_q2 <= r_q1;
        end
    end

    assign o_z    = r_z;
    assign o_quad = r_q2;
endmodule
`default_nettype wire

### rtl/core/atr_cordic_cell.sv
// One CORDIC rotation step, registered.
`default_nettype none
module atr_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire atr_pkg::t_cvec i_vec,
    output atr_pkg::t_cvec      o_vec
);
    import atr_pkg::*;

    logic signed [CW-1:0] x, y, z, dx, dy, ang;
    t_cvec n_vec, r_vec;

    always_comb begin
        x   = $signed(i_vec.x);
        y   = $signed(i_vec.y);
        z   = $signed(i_vec.z);
        dx  = y >>> STEP;
        dy  = x >>> STEP;
        ang = $signed({2'b00, ATAN_TAB[STEP]});
        if (!z[CW-1]) begin
            n_vec.x = x - dx;
            n_vec.y = y + dy;
            n_vec.z = z - ang;
        end else begin
            n_vec.x = x + dx;
            n_vec.y = y - dy;
            n_vec.z = z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_vec <= n_vec;
    end

    assign o_vec = r_vec;
endmodule
`default_nettype wire

### rtl/core/atr_tensor.sv
// Quadrant mapping, ZXZ matrix build, tensor terms and saturation: ten stages.
`default_nettype none
module atr_tensor (
    input  wire logic                        i_clk,
    input  wire logic [9:0]                  i_en,
    input  wire atr_pkg::t_cvec              i_vec  [atr_pkg::N_LANE],
    input  wire atr_pkg::t_quad              i_quad [atr_pkg::N_LANE],
    input  wire logic [atr_pkg::COND_W-1:0]  i_cond [atr_pkg::N_LANE],
    output logic signed [atr_pkg::OUT_W-1:0] o_t    [atr_pkg::N_ENT]
);
    import atr_pkg::*;

    localparam logic signed [55:0] SAT_HI = 56'sd281474976710655;
    localparam logic signed [55:0] SAT_LO = -56'sd281474976710656;

    logic signed [MW-1:0] n_c [N_LANE], n_s [N_LANE];
    logic signed [MW-1:0] r_c [N_LANE], r_s [N_LANE];

    // first product: Rz(first) * Rx(second)
    logic signed [PW-1:0] r_p_s1c2, r_p_s1s2, r_p_c1c2, r_p_c1s2, r_p_s2s3, r_p_s2c3;
    logic signed [MW-1:0] r_c1a, r_s1a, r_c2a, r_c3a, r_s3a;
    logic signed [MW-1:0] r_t00, r_t01, r_t02, r_t10, r_t11, r_t12;
    logic signed [MW-1:0] r_m20, r_m21, r_m22, r_c3b, r_s3b;
    // second product: times Rz(third)
    logic signed [PW-1:0] r_q [8];
    logic signed [MW-1:0] r_t02b, r_t12b, r_m20b, r_m21b, r_m22b;
    logic signed [MW-1:0] r_rm [3][3];
    logic signed [PW-1:0] r_pr [N_ENT][N_LANE];
    logic signed [32:0]   r_w  [N_ENT][N_LANE];
    logic signed [57:0]   r_a  [N_ENT][N_LANE], r_b [N_ENT][N_LANE];
    logic signed [83:0]   e    [N_ENT][N_LANE];
    logic signed [53:0]   r_term [N_ENT][N_LANE];
    logic signed [55:0]   acc  [N_ENT];
    logic signed [OUT_W-1:0] n_t [N_ENT], r_t [N_ENT];
    logic signed [35:0]   rd [10];

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            unique case (i_quad[l])
                QUAD_1: begin
                    n_c[l] = MW'(-$signed(i_vec[l].y)); n_s[l] = MW'($signed(i_vec[l].x));
                end
                QUAD_2: begin
                    n_c[l] = MW'(-$signed(i_vec[l].x)); n_s[l] = MW'(-$signed(i_vec[l].y));
                end
                QUAD_3: begin
                    n_c[l] = MW'($signed(i_vec[l].y)); n_s[l] = MW'(-$signed(i_vec[l].x));
                end
                default: begin
                    n_c[l] = MW'($signed(i_vec[l].x)); n_s[l] = MW'($signed(i_vec[l].y));
                end
            endcase
        end
    end

    always_comb begin
        rd[0] = rnd30(-r_p_s1c2);
        rd[1] = rnd30(r_p_s1s2);
        rd[2] = rnd30(r_p_c1c2);
        rd[3] = rnd30(-r_p_c1s2);
        rd[4] = rnd30(r_p_s2s3);
        rd[5] = rnd30(r_p_s2c3);
        rd[6] = rnd30(r_q[0] + r_q[1]);
        rd[7] = rnd30(r_q[3] - r_q[2]);
        rd[8] = rnd30(r_q[4] + r_q[5]);
        rd[9] = rnd30(r_q[7] - r_q[6]);
    end

    always_comb begin
        for (int n = 0; n < N_ENT; n++) begin
            acc[n] = 56'(r_term[n][0]) + 56'(r_term[n][1]) + 56'(r_term[n][2]);
            priority if (acc[n] > SAT_HI) n_t[n] = SAT_HI[OUT_W-1:0];
            else if (acc[n] < SAT_LO)     n_t[n] = SAT_LO[OUT_W-1:0];
            else                          n_t[n] = acc[n][OUT_W-1:0];
            for (int k = 0; k < N_LANE; k++) begin
                e[n][k] = (84'(r_a[n][k]) <<< 24) + 84'(r_b[n][k]) + 84'(HALF_Q30);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_c <= n_c;
            r_s <= n_s;
        end
        if (i_en[1]) begin
            r_p_s1c2 <= r_s[0] * r_c[1];
            r_p_s1s2 <= r_s[0] * r_s[1];
            r_p_c1c2 <= r_c[0] * r_c[1];
            r_p_c1s2 <= r_c[0] * r_s[1];
            r_p_s2s3 <= r_s[1] * r_s[2];
            r_p_s2c3 <= r_s[1] * r_c[2];
            r_c1a <= r_c[0];
            r_s1a <= r_s[0];
            r_c2a <= r_c[1];
            r_c3a <= r_c[2];
            r_s3a <= r_s[2];
        end
        if (i_en[2]) begin
            r_t00 <= r_c1a;
            r_t10 <= r_s1a;
            r_t01 <= rd[0][MW-1:0];
            r_t02 <= rd[1][MW-1:0];
            r_t11 <= rd[2][MW-1:0];
            r_t12 <= rd[3][MW-1:0];
            r_m20 <= rd[4][MW-1:0];
            r_m21 <= rd[5][MW-1:0];
            r_m22 <= r_c2a;
            r_c3b <= r_c3a;
            r_s3b <= r_s3a;
        end
        if (i_en[3]) begin
            r_q[0] <= r_t00 * r_c3b;
            r_q[1] <= r_t01 * r_s3b;
            r_q[2] <= r_t00 * r_s3b;
            r_q[3] <= r_t01 * r_c3b;
            r_q[4] <= r_t10 * r_c3b;
            r_q[5] <= r_t11 * r_s3b;
            r_q[6] <= r_t10 * r_s3b;
            r_q[7] <= r_t11 * r_c3b;
            r_t02b <= r_t02;
            r_t12b <= r_t12;
            r_m20b <= r_m20;
            r_m21b <= r_m21;
            r_m22b <= r_m22;
        end
        if (i_en[4]) begin
            r_rm[0][0] <= rd[6][MW-1:0];
            r_rm[0][1] <= rd[7][MW-1:0];
            r_rm[0][2] <= r_t02b;
            r_rm[1][0] <= rd[8][MW-1:0];
            r_rm[1][1] <= rd[9][MW-1:0];
            r_rm[1][2] <= r_t12b;
            r_rm[2][0] <= r_m20b;
            r_rm[2][1] <= r_m21b;
            r_rm[2][2] <= r_m22b;
        end
        for (int n = 0; n < N_ENT; n++) begin
            for (int k = 0; k < N_LANE; k++) begin
                if (i_en[5]) r_pr[n][k] <= r_rm[ENT_I[n]][k] * r_rm[ENT_J[n]][k];
                if (i_en[6]) r_w[n][k] <= 33'(rnd30(r_pr[n][k]));
                if (i_en[7]) begin
                    r_a[n][k] <= r_w[n][k] * $signed({1'b0, i_cond[k][47:24]});
                    r_b[n][k] <= r_w[n][k] * $signed({1'b0, i_cond[k][23:0]});
                end
                if (i_en[8]) r_term[n][k] <= e[n][k][83:30];
            end
        end
        if (i_en[9]) r_t <= n_t;
    end

    assign o_t = r_t;
endmodule
`default_nettype wire

### rtl/core/anisotropic_tensor_rotation_top.sv
// Throughput: one beat per cycle while the sink is ready; the 30-cell
// CORDIC chain and the multiplier stages all advance together, each stage
// holding only when the stage after it is full and stalled.
// Reset: synchronous, active low; clears the stage valid bits only.
// Top level: angle prep, CORDIC cell chain, tensor stages, stall control.
`default_nettype none
module anisotropic_tensor_rotation_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    // cond_x, cond_y, cond_z, angle_first, angle_second, angle_third, pad
    input  wire logic [atr_pkg::IN_DW-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    // t_xx, t_xy, t_xz, t_yy, t_yz, t_zz, pad
    output logic [atr_pkg::OUT_DW-1:0]      o_m_tdata
);
    import atr_pkg::*;

    localparam int PREP_ST = 3;
    localparam int CORD0   = PREP_ST;
    localparam int TEN0    = CORD0 + CORDIC_STEPS;
    localparam int NST     = TEN0 + 10;
    localparam int COND_ST = TEN0 + 7;   // tensor stage that uses the conductivities

    logic [NST-1:0] r_vld;
    logic [NST:0]   en;

    logic [COND_W-1:0] r_cd [COND_ST][N_LANE];
    t_quad             r_qd [CORDIC_STEPS][N_LANE];
    t_quad             quad_p [N_LANE];
    logic [CW-1:0]     z_p [N_LANE];
    t_cvec             vec [N_LANE][CORDIC_STEPS+1];
    t_cvec             vec_end [N_LANE];
    t_quad             quad_end [N_LANE];
    logic signed [OUT_W-1:0] tens [N_ENT];

    always_comb begin
        en[NST] = i_m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // side delay lines for conductivities and quadrants
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_cd[0][0] <= i_s_tdata[47:0];
            r_cd[0][1] <= i_s_tdata[95:48];
            r_cd[0][2] <= i_s_tdata[143:96];
        end
        for (int k = 1; k < COND_ST; k++) begin
            if (en[k]) r_cd[k] <= r_cd[k-1];
        end
        if (en[CORD0]) r_qd[0] <= quad_p;
        for (int j = 1; j < CORDIC_STEPS; j++) begin
            if (en[CORD0+j]) r_qd[j] <= r_qd[j-1];
        end
    end

    for (genvar l = 0; l < N_LANE; l++) begin : g_lane
        atr_angle_prep u_prep (
            .i_clk   (i_clk),
            .i_en    (en[PREP_ST-1:0]),
            .i_angle ($signed(i_s_tdata[144+ANG_W*l +: ANG_W])),
            .o_z     (z_p[l]),
            .o_quad  (quad_p[l])
        );

        assign vec[l][0] = '{x: CORDIC_GAIN, y: '0, z: z_p[l]};

        for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cell
            atr_cordic_cell #(.STEP(j)) u_cell (
                .i_clk (i_clk),
                .i_en  (en[CORD0+j]),
                .i_vec (vec[l][j]),
                .o_vec (vec[l][j+1])
            );
        end

        assign vec_end[l]  = vec[l][CORDIC_STEPS];
        assign quad_end[l] = r_qd[CORDIC_STEPS-1][l];
    end

    atr_tensor u_tensor (
        .i_clk  (i_clk),
        .i_en   (en[NST-1:TEN0]),
        .i_vec  (vec_end),
        .i_quad (quad_end),
        .i_cond (r_cd[COND_ST-1]),
        .o_t    (tens)
    );

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = {2'b00, tens[5], tens[4], tens[3], tens[2], tens[1], tens[0]};
endmodule
`default_nettype wire

### rtl/core/atr_checker.sv
// Port-level checks on the top level, bound to it.
`default_nettype none
module atr_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_tvalid,
    input wire logic                      o_s_tready,
    input wire logic [atr_pkg::IN_DW-1:0] i_s_tdata,
    input wire logic                      o_m_tvalid,
    input wire logic                      i_m_tready,
    input wire logic [atr_pkg::OUT_DW-1:0] o_m_tdata
);
    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result beat right after reset");

    // an empty output stage means nothing blocks the input
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // sink ready lets every stage advance
    a_sink_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while sink ready");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result beat changed while stalled");
endmodule

bind anisotropic_tensor_rotation_top atr_checker u_atr_checker (.*);
`default_nettype wire
